// ===== hdl/wcmp_pkg.sv =====
package wcmp_pkg;

    // Field widths
    localparam int WORD_W   = 64;
    localparam int CNT_W    = 32;
    localparam int LOW_W    = 8;
    localparam int SKIP_W   = 3;
    localparam int BIN_O_W  = 3;

    // Stream data widths
    localparam int IN_TDATA_W  = 128;
    localparam int OUT_TDATA_W = 264;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAL_ENABLE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_MODE   = 1'b1;

    // Pairs skipped after a byte-mode mismatch
    localparam logic [SKIP_W-1:0] SKIP_STRIDE = 3'd7;

    // Default histogram size
    localparam int HISTO_BINS_DEF = 8;

    // Per-item result of the compare stage
    typedef struct packed {
        logic [WORD_W-1:0] pos;
        logic [WORD_W-1:0] right;
        logic              mism;
        logic              healed;
        logic              lzero;
        logic [CNT_W-1:0]  berr;
        logic [CNT_W-1:0]  fix;
        logic [CNT_W-1:0]  lfix;
    } t_result;

    // Complete result item
    typedef struct packed {
        t_result            res;
        logic [BIN_O_W-1:0] bin;
        logic [CNT_W-1:0]   count;
    } t_out;

    // Saturating increment of a counter
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : v + {{(CNT_W-1){1'b0}}, 1'b1};
    endfunction

endpackage

// ===== hdl/wcmp_ram.sv =====
module wcmp_ram
    #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
    )(
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
    );

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

// ===== hdl/wcmp_core.sv =====
module wcmp_core
    import wcmp_pkg::*;
    #(
    parameter int HISTO_BINS = HISTO_BINS_DEF
    )(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic [WORD_W-1:0]             i_left,
    input  logic [WORD_W-1:0]             i_right,
    input  logic                          i_last,
    input  logic                          i_heal,
    input  logic                          i_byte,
    output t_result                       o_res,
    output logic                          o_hist_inc,
    output logic [$clog2(HISTO_BINS)-1:0] o_hist_bin
    );

    localparam int BIN_W = $clog2(HISTO_BINS);

    logic [SKIP_W-1:0] r_skip, n_skip;
    logic [WORD_W-1:0] r_pos;
    logic [CNT_W-1:0]  r_berr, n_berr, r_fix, n_fix, r_lfix, n_lfix;
    logic [WORD_W-1:0] l_w, r_w;

    // Compare, heal and buffer bookkeeping for one item
    always_comb begin
        l_w = i_byte ? {{(WORD_W-LOW_W){1'b0}}, i_left[LOW_W-1:0]}  : i_left;
        r_w = i_byte ? {{(WORD_W-LOW_W){1'b0}}, i_right[LOW_W-1:0]} : i_right;
        n_skip = r_skip;
        n_berr = r_berr;
        n_fix  = r_fix;
        n_lfix = r_lfix;
        o_res.mism   = 1'b0;
        o_res.healed = 1'b0;
        o_res.lzero  = 1'b0;
        o_res.right  = r_w;

        if (r_skip != '0) begin
            n_skip = r_skip - {{(SKIP_W-1){1'b0}}, 1'b1};
        end else if (l_w != r_w) begin
            o_res.mism = 1'b1;
            n_berr = sat_inc(r_berr);
            if (i_byte) begin
                n_skip = SKIP_STRIDE;
            end
            // upper parts equal: look at the low bytes
            if (i_heal && (l_w[WORD_W-1:LOW_W] == r_w[WORD_W-1:LOW_W])) begin
                if ((l_w[LOW_W-1:0] != '0) && (r_w[LOW_W-1:0] == '0)) begin
                    o_res.right  = l_w;
                    o_res.healed = 1'b1;
                    n_fix = sat_inc(r_fix);
                end else if ((l_w[LOW_W-1:0] == '0) && (r_w[LOW_W-1:0] != '0)) begin
                    o_res.lzero = 1'b1;
                    n_lfix = sat_inc(r_lfix);
                end
            end
        end

        o_res.pos  = r_pos;
        o_res.berr = n_berr;
        o_res.fix  = n_fix;
        o_res.lfix = n_lfix;

        // histogram request at the end of a buffer with errors
        o_hist_inc = i_last && (n_berr != '0);
        o_hist_bin = (n_berr < CNT_W'(HISTO_BINS - 1)) ? n_berr[BIN_W-1:0]
                                                       : BIN_W'(HISTO_BINS - 1);

        if (i_last) begin
            n_berr = '0;
            n_skip = '0;
        end
    end

    // State update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip <= '0;
            r_pos  <= '0;
            r_berr <= '0;
            r_fix  <= '0;
            r_lfix <= '0;
        end else if (i_en) begin
            r_skip <= n_skip;
            r_pos  <= r_pos + {{(WORD_W-1){1'b0}}, 1'b1};
            r_berr <= n_berr;
            r_fix  <= n_fix;
            r_lfix <= n_lfix;
        end
    end

endmodule

// ===== hdl/wcmp_histo.sv =====
module wcmp_histo
    import wcmp_pkg::*;
    #(
    parameter int HISTO_BINS = HISTO_BINS_DEF
    )(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  t_result                       i_res,
    input  logic                          i_inc,
    input  logic [$clog2(HISTO_BINS)-1:0] i_bin,
    output logic                          o_valid,
    output t_out                          o_out
    );

    localparam int BIN_W = $clog2(HISTO_BINS);

    logic                  r_mid_v;
    t_result               r_mid_res;
    logic                  r_mid_inc;
    logic [BIN_W-1:0]      r_mid_bin;
    logic [HISTO_BINS-1:0] r_bin_vld;
    logic                  r_wr_vld;
    logic [BIN_W-1:0]      r_wr_addr;
    logic [CNT_W-1:0]      r_wr_data;
    logic [CNT_W-1:0]      rd_data, cur, upd;
    logic                  wr_en;
    logic [BIN_W-1:0]      rd_addr;

    // Bin storage, read issued in the cycle before the stage holds the bin, held on the stage bin while stalled
    wcmp_ram #(
        .WIDTH (CNT_W),
        .DEPTH (HISTO_BINS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_mid_bin),
        .i_wr_data (upd),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Current bin value: forward last write, unwritten bins read as zero
    always_comb begin
        rd_addr = i_en ? i_bin : r_mid_bin;
        if (r_wr_vld && (r_wr_addr == r_mid_bin)) begin
            cur = r_wr_data;
        end else if (r_bin_vld[r_mid_bin]) begin
            cur = rd_data;
        end else begin
            cur = '0;
        end
        upd   = sat_inc(cur);
        wr_en = i_en && r_mid_v && r_mid_inc;

        o_valid     = r_mid_v;
        o_out.res   = r_mid_res;
        o_out.bin   = r_mid_inc ? BIN_O_W'(r_mid_bin) : '0;
        o_out.count = r_mid_inc ? upd : '0;
    end

    // Stage register and write tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_v   <= 1'b0;
            r_bin_vld <= '0;
            r_wr_vld  <= 1'b0;
        end else begin
            if (i_en) begin
                r_mid_v <= i_valid;
            end
            if (wr_en) begin
                r_bin_vld[r_mid_bin] <= 1'b1;
                r_wr_vld             <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mid_res <= i_res;
            r_mid_inc <= i_inc && i_valid;
            r_mid_bin <= i_bin;
        end
        if (wr_en) begin
            r_wr_addr <= r_mid_bin;
            r_wr_data <= upd;
        end
    end

endmodule

// ===== hdl/word_compare_with_heal.sv =====
// Word pair checker with low-byte heal. Takes one reference/captured word pair
// per cycle on the slave stream while the output is not held, and returns one
// result item per pair, offered on the master stream after three register
// stages (input register, histogram stage, result register). One item per
// clock while the output is not held; the read-modify-write of the histogram
// bin RAM forwards its last write so back-to-back buffer ends on the same bin
// count correctly. Bins are tracked with one valid bit each, so the block is
// ready right after reset with no clearing pass.
// Configuration writes are always accepted and must be made while idle.
module word_compare_with_heal
    import wcmp_pkg::*;
    #(
    parameter int HISTO_BINS = HISTO_BINS_DEF
    )(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // cfg: index 0 heal_enable, 1 byte_mode
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    // slave stream
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,  // left_word[63:0], right_word[127:64]
    input  logic                   i_s_axis_tlast,  // last_in_buffer
    // master stream
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // word_position[63:0], right_word_out[127:64], mismatch[128], healed[129],
    // left_zero_case[130], buffer_error_count[162:131], histogram_bin[165:163],
    // histogram_count[197:166], total_fixups[229:198], total_left_fix[261:230]
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata
    );

    localparam int BIN_W = $clog2(HISTO_BINS);

    logic              r_heal, r_byte;
    logic              r_in_v;
    logic [WORD_W-1:0] r_in_left, r_in_right;
    logic              r_in_last;
    logic              r_out_v;
    t_out              r_out;
    logic              en;
    t_result           core_res;
    logic              hist_inc;
    logic [BIN_W-1:0]  hist_bin;
    logic              mid_v;
    t_out              mid_out;

    // Whole pipeline advances unless the output is held
    assign en              = !r_out_v || i_m_axis_tready;
    assign o_s_axis_tready = en;
    assign o_cfg_ready     = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heal <= 1'b0;
            r_byte <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_HEAL_ENABLE: r_heal <= i_cfg_data[0];
                CFG_BYTE_MODE:   r_byte <= i_cfg_data[0];
                default:         ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (en) begin
            r_in_v <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in_left  <= i_s_axis_tdata[WORD_W-1:0];
            r_in_right <= i_s_axis_tdata[2*WORD_W-1:WORD_W];
            r_in_last  <= i_s_axis_tlast;
        end
    end

    wcmp_core #(
        .HISTO_BINS (HISTO_BINS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en && r_in_v),
        .i_left     (r_in_left),
        .i_right    (r_in_right),
        .i_last     (r_in_last),
        .i_heal     (r_heal),
        .i_byte     (r_byte),
        .o_res      (core_res),
        .o_hist_inc (hist_inc),
        .o_hist_bin (hist_bin)
    );

    wcmp_histo #(
        .HISTO_BINS (HISTO_BINS)
    ) u_histo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_in_v),
        .i_res   (core_res),
        .i_inc   (hist_inc),
        .i_bin   (hist_bin),
        .o_valid (mid_v),
        .o_out   (mid_out)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= mid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= mid_out;
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = {2'b00, r_out.res.lfix, r_out.res.fix, r_out.count, r_out.bin,
                              r_out.res.berr, r_out.res.lzero, r_out.res.healed,
                              r_out.res.mism, r_out.res.right, r_out.res.pos};

endmodule

// ===== sim/tb_word_compare_with_heal.sv =====
module tb_word_compare_with_heal;
    timeunit 1ns;
    timeprecision 1ps;

    import wcmp_pkg::*;

    localparam int NBINS = HISTO_BINS_DEF;

    // One expected or observed result item
    typedef struct packed {
        logic [WORD_W-1:0]  pos;
        logic [WORD_W-1:0]  word;
        logic               mism;
        logic               healed;
        logic               lzero;
        logic [CNT_W-1:0]   berr;
        logic [BIN_O_W-1:0] bin;
        logic [CNT_W-1:0]   bcount;
        logic [CNT_W-1:0]   fixups;
        logic [CNT_W-1:0]   lfixes;
    } pair_result_t;

    // Receiver stall styles
    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_style_e;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic                   i_s_axis_tlast = 1'b0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;

    word_compare_with_heal dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    // Predictor state, mirrors the checker's registers and totals
    logic              heal_on = 1'b0;
    logic              byte_on = 1'b0;
    logic [SKIP_W-1:0] skip_left = '0;
    logic [WORD_W-1:0] pos_count = '0;
    logic [CNT_W-1:0]  buf_errs = '0;
    logic [CNT_W-1:0]  fix_tot = '0;
    logic [CNT_W-1:0]  lfix_tot = '0;
    logic [CNT_W-1:0]  err_histo [NBINS] = '{default: '0};

    pair_result_t pending_results [$];
    int fail_count = 0;
    int checked_count = 0;
    int burst_left = 0;
    int sent_count = 0;
    int n_mism = 0, n_heal = 0, n_lzero = 0, n_hist = 0, n_top_bin = 0;

    function automatic logic [CNT_W-1:0] sat_bump(input logic [CNT_W-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    // Expected result of one word pair; advances the predictor state
    function automatic pair_result_t predict_pair(input logic [WORD_W-1:0] lw_in, rw_in,
                                                  input logic last);
        pair_result_t res;
        logic [WORD_W-1:0] lw, rw;
        int b;
        lw = lw_in;
        rw = rw_in;
        res = '0;
        res.pos = pos_count;
        if (byte_on) begin
            lw = {{(WORD_W-LOW_W){1'b0}}, lw[LOW_W-1:0]};
            rw = {{(WORD_W-LOW_W){1'b0}}, rw[LOW_W-1:0]};
        end
        if (skip_left != 0) begin
            skip_left = skip_left - 1'b1;
        end else if (lw != rw) begin
            res.mism = 1'b1;
            buf_errs = sat_bump(buf_errs);
            if (byte_on)
                skip_left = SKIP_STRIDE;
            if (heal_on && lw[WORD_W-1:LOW_W] == rw[WORD_W-1:LOW_W]) begin
                if (lw[LOW_W-1:0] != 0 && rw[LOW_W-1:0] == 0) begin
                    rw = lw;
                    res.healed = 1'b1;
                    fix_tot = sat_bump(fix_tot);
                end else if (lw[LOW_W-1:0] == 0 && rw[LOW_W-1:0] != 0) begin
                    res.lzero = 1'b1;
                    lfix_tot = sat_bump(lfix_tot);
                end
            end
        end
        res.berr = buf_errs;
        // buffer end: bump the bin of a buffer with errors, clear skip
        if (last) begin
            if (buf_errs != 0) begin
                b = (buf_errs < NBINS - 1) ? int'(buf_errs) : NBINS - 1;
                err_histo[b] = sat_bump(err_histo[b]);
                res.bin = BIN_O_W'(b);
                res.bcount = err_histo[b];
                n_hist++;
                if (b == NBINS - 1)
                    n_top_bin++;
            end
            buf_errs = '0;
            skip_left = '0;
        end
        pos_count = pos_count + 1'b1;
        res.word = rw;
        res.fixups = fix_tot;
        res.lfixes = lfix_tot;
        n_mism += res.mism;
        n_heal += res.healed;
        n_lzero += res.lzero;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got, want);
        fail_count++;
        if (fail_count <= 40)
            $display("result %0d: %s got 0x%0h, expected 0x%0h", checked_count, what, got, want);
    endtask

    task automatic compare_field(input string what, input logic [WORD_W-1:0] got, want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // Result checker
    always @(posedge i_clk) begin : check_results
        pair_result_t got, want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.pos    = o_m_axis_tdata[63:0];
            got.word   = o_m_axis_tdata[127:64];
            got.mism   = o_m_axis_tdata[128];
            got.healed = o_m_axis_tdata[129];
            got.lzero  = o_m_axis_tdata[130];
            got.berr   = o_m_axis_tdata[162:131];
            got.bin    = o_m_axis_tdata[165:163];
            got.bcount = o_m_axis_tdata[197:166];
            got.fixups = o_m_axis_tdata[229:198];
            got.lfixes = o_m_axis_tdata[261:230];
            if (pending_results.size() == 0) begin
                report_mismatch("item with nothing pending, word_position", got.pos, '0);
            end else begin
                want = pending_results.pop_front();
                compare_field("word_position", got.pos, want.pos);
                compare_field("right_word_out", got.word, want.word);
                compare_field("mismatch", WORD_W'(got.mism), WORD_W'(want.mism));
                compare_field("healed", WORD_W'(got.healed), WORD_W'(want.healed));
                compare_field("left_zero_case", WORD_W'(got.lzero), WORD_W'(want.lzero));
                compare_field("buffer_error_count", WORD_W'(got.berr), WORD_W'(want.berr));
                compare_field("histogram_bin", WORD_W'(got.bin), WORD_W'(want.bin));
                compare_field("histogram_count", WORD_W'(got.bcount), WORD_W'(want.bcount));
                compare_field("total_fixups", WORD_W'(got.fixups), WORD_W'(want.fixups));
                compare_field("total_left_fix", WORD_W'(got.lfixes), WORD_W'(want.lfixes));
            end
            checked_count++;
        end
    end

    // Receiver backpressure: a style held for a random stretch, then another
    rx_style_e rx_style = RX_OPEN;
    int        rx_ticks = 0;
    logic [1:0] rx_phase = '0;

    always @(posedge i_clk) begin
        rx_phase <= rx_phase + 1'b1;
        if (rx_ticks == 0) begin
            rx_style <= rx_style_e'($urandom_range(0, 3));
            rx_ticks <= $urandom_range(16, 128);
        end else begin
            rx_ticks <= rx_ticks - 1;
        end
        case (rx_style)
            RX_OPEN:     i_m_axis_tready <= 1'b1;
            RX_COIN:     i_m_axis_tready <= ($urandom_range(0, 1) == 1);
            RX_PERIODIC: i_m_axis_tready <= (rx_phase == 2'd0);
            default:     i_m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Send one word pair; bursts of random length with random gaps between
    task automatic push_pair(input logic [WORD_W-1:0] lw, rw, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap) begin
                i_s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {rw, lw};
        i_s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        pending_results.push_back(predict_pair(lw, rw, last));
        burst_left--;
        sent_count++;
    endtask

    // Hold the sender until every pending result has come back
    task automatic wait_results_drained();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_HEAL_ENABLE)
            heal_on = val[0];
        else
            byte_on = val[0];
        @(posedge i_clk);
    endtask

    task automatic set_mode(input logic heal, input logic bytes);
        wait_results_drained();
        write_reg(CFG_HEAL_ENABLE, heal);
        write_reg(CFG_BYTE_MODE, bytes);
    endtask

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [WORD_W-1:0] extreme_word();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            2:       return WORD_W'(8'hFF);
            default: return ~WORD_W'(8'hFF);
        endcase
    endfunction

    // Random pair, weighted toward equal words and heal-shaped mismatches
    task automatic make_pair(output logic [WORD_W-1:0] lw, rw);
        int pick;
        logic [WORD_W-1:0] noise;
        pick = $urandom_range(0, 99);
        lw = rand_word();
        noise = rand_word();
        rw = lw;
        if (pick < 40) begin
            // equal; in byte mode the upper parts may differ freely
            if (byte_on && $urandom_range(0, 1) == 1)
                rw[WORD_W-1:LOW_W] = noise[WORD_W-1:LOW_W];
        end else if (pick < 55) begin
            lw[LOW_W-1:0] = LOW_W'($urandom_range(1, 255));
            rw = {lw[WORD_W-1:LOW_W], {LOW_W{1'b0}}};
        end else if (pick < 67) begin
            lw[LOW_W-1:0] = '0;
            rw = {lw[WORD_W-1:LOW_W], LOW_W'($urandom_range(1, 255))};
        end else if (pick < 75) begin
            rw[LOW_W-1:0] = lw[LOW_W-1:0] ^ LOW_W'($urandom_range(1, 255));
        end else if (pick < 85) begin
            rw = lw ^ (WORD_W'(1) << $urandom_range(LOW_W, WORD_W - 1));
            if ($urandom_range(0, 1) == 1)
                rw[LOW_W-1:0] = '0;
        end else if (pick < 95) begin
            rw = noise;
        end else begin
            lw = extreme_word();
            rw = extreme_word();
        end
    endtask

    // Full-word compare with extreme values, heal off
    task automatic test_word_compare();
        push_pair('0, '0, 1'b0);
        push_pair('1, '1, 1'b0);
        push_pair('0, '1, 1'b0);
        push_pair('1, '0, 1'b1);
    endtask

    // Repair, left-zero case and the mismatches that heal leaves alone
    task automatic test_heal_cases();
        set_mode(1'b1, 1'b0);
        push_pair(64'h0123_4567_89AB_CDEF, 64'h0123_4567_89AB_CD00, 1'b0);
        push_pair(64'hFEDC_BA98_7654_3200, 64'hFEDC_BA98_7654_32C5, 1'b0);
        push_pair(64'h5555_AAAA_0F0F_F011, 64'h5555_AAAA_0F0F_F022, 1'b0);
        push_pair(64'h8000_0000_0000_0042, 64'h0000_0000_0000_0000, 1'b0);
        push_pair(64'hC3C3_3C3C_0000_0001, 64'hC3C3_3C3C_0000_0001, 1'b1);
    endtask

    // Byte mode: skip after mismatch, skip cleared at buffer end, clean buffer
    task automatic test_byte_skip();
        set_mode(1'b0, 1'b1);
        push_pair(64'h12, 64'hFFFF_FFFF_FFFF_FF13, 1'b0);
        push_pair(64'hAA, 64'h55, 1'b0);
        push_pair('0, '1, 1'b1);
        push_pair(64'h3C, 64'h3D, 1'b1);
        push_pair(64'hDEAD_BEEF_0000_0077, 64'h77, 1'b1);
    endtask

    // A pending skip keeps counting down after switching to word mode
    task automatic test_mode_change_skip();
        push_pair(64'h00, 64'h5A, 1'b0);
        set_mode(1'b1, 1'b0);
        push_pair(64'h7777_0000_1111_22AB, 64'h7777_0000_1111_2200, 1'b0);
        push_pair('0, '1, 1'b1);
    endtask

    // As many errors in one buffer as there are bins: lands in the top bin
    task automatic test_top_bin();
        logic [WORD_W-1:0] w;
        set_mode(1'b0, 1'b0);
        for (int k = 0; k < 8; k++) begin
            w = rand_word();
            push_pair(w, ~w, k == 7);
        end
    endtask

    // Random buffers through every mode setting, one drain pause per phase
    task automatic test_random_traffic();
        logic [WORD_W-1:0] lw, rw;
        logic [2:0] p;
        int buf_left;
        int hold_at;
        buf_left = 0;
        for (int ph = 0; ph < 8; ph++) begin
            p = 3'(ph);
            set_mode(p[0] ^ p[2], p[1]);
            hold_at = $urandom_range(20, 120);
            for (int k = 0; k < 144; k++) begin
                if (k == hold_at)
                    wait_results_drained();
                if (buf_left == 0)
                    buf_left = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40)
                                                           : $urandom_range(1, 8);
                make_pair(lw, rw);
                push_pair(lw, rw, buf_left == 1);
                buf_left--;
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_word_compare();
        test_heal_cases();
        test_byte_skip();
        test_mode_change_skip();
        test_top_bin();
        test_random_traffic();
        wait_results_drained();
        repeat (8) @(posedge i_clk);
        $display("%0d word pairs over all heal/byte settings: %0d mismatches, %0d repairs, %0d left-zero",
                 sent_count, n_mism, n_heal, n_lzero);
        $display("%0d histogram updates, %0d of them into the top bin", n_hist, n_top_bin);
        if (fail_count == 0)
            $display("[word_compare_with_heal] OK");
        else
            $display("[word_compare_with_heal] ERROR");
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("timeout with %0d results pending", pending_results.size());
        $display("[word_compare_with_heal] ERROR");
        $finish;
    end

endmodule
